// File: hdl/bipm_pkg.sv
// shared types and codes for the buffer index pool manager
`default_nettype none
package bipm_pkg;

	// command codes on the input word
	localparam logic [1:0] CMD_PUT     = 2'd0;
	localparam logic [1:0] CMD_RECYCLE = 2'd1;
	localparam logic [1:0] CMD_DRAIN   = 2'd2;

	// classified operations handed from front to back
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_REC   = 2'd1;
	localparam logic [1:0] OP_DRAIN = 2'd2;
	localparam logic [1:0] OP_BAD   = 2'd3;

	// result status codes
	localparam logic [2:0] RC_OK         = 3'd0;
	localparam logic [2:0] RC_NO_IDLE    = 3'd1;
	localparam logic [2:0] RC_NOT_INUSE  = 3'd2;
	localparam logic [2:0] RC_IDLE_FULL  = 3'd3;
	localparam logic [2:0] RC_READY_FULL = 3'd4;
	localparam logic [2:0] RC_RANGE      = 3'd5;

	localparam logic [6:0] COUNT_MAX = 7'd127;

	// classified command
	typedef struct packed {
		logic [1:0] op;
		logic [3:0] q;
		logic [9:0] idx;
		logic       list_last;
	} bipm_cmd_t;

	// one result word
	typedef struct packed {
		logic [2:0] status;
		logic [9:0] index;
		logic       index_valid;
		logic       alarm;
		logic       wake;
		logic       last;
	} bipm_res_t;

endpackage
`default_nettype wire

// File: hdl/bipm_ram.sv
// generic single write port ram with registered read
`default_nettype none
module bipm_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: hdl/bipm_front.sv
// front end: accepts command words, classifies them, two-entry queue
`default_nettype none
module bipm_front #(
	parameter int NUM_QUEUES  = 4,
	parameter int QUEUE_DEPTH = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        cmd,
	input  wire logic [1:0]        queue_sel,
	input  wire logic [9:0]        index_in,
	input  wire logic              list_last,
	output logic                   cq_valid,
	output bipm_pkg::bipm_cmd_t    cq,
	input  wire logic              cq_take
);
	import bipm_pkg::*;

	localparam int POOL = NUM_QUEUES * QUEUE_DEPTH;

	bipm_cmd_t  ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	bipm_cmd_t  cls;
	logic [3:0] owner;
	logic       push;
	logic       pop;

	// owning queue of a recycled index
	always_comb begin
		owner = 4'd0;
		for (int k = 1; k < NUM_QUEUES; k++) begin
			if (int'(index_in) >= k * QUEUE_DEPTH) begin
				owner = 4'(k);
			end
		end
	end

	// classify the incoming word
	always_comb begin
		cls.q         = 4'(queue_sel);
		cls.idx       = index_in;
		cls.list_last = list_last;
		case (cmd)
			CMD_PUT: begin
				cls.op = (int'(queue_sel) < NUM_QUEUES) ? OP_PUT : OP_BAD;
			end
			CMD_RECYCLE: begin
				cls.op = (int'(index_in) < POOL) ? OP_REC : OP_BAD;
				cls.q  = owner;
			end
			CMD_DRAIN: begin
				cls.op = OP_DRAIN;
			end
			default: begin
				cls.op = OP_BAD;
			end
		endcase
	end

	assign in_stall = !en || (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign pop      = cq_take && cq_valid;
	assign cq_valid = (cnt_q != 2'd0);
	assign cq       = ent_q[rp_q];

	// command queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// File: hdl/bipm_exec.sv
// back end: sequencer over the free, ready and in-use stores
`default_nettype none
module bipm_exec #(
	parameter int NUM_QUEUES  = 4,
	parameter int QUEUE_DEPTH = 256,
	parameter int DRAIN_MAX   = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	output logic                      init_done,
	input  wire logic                 cq_valid,
	input  wire bipm_pkg::bipm_cmd_t  cq,
	output logic                      cq_take,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output bipm_pkg::bipm_res_t       out_res
);
	import bipm_pkg::*;

	localparam int POOL      = NUM_QUEUES * QUEUE_DEPTH;
	localparam int PW        = $clog2(POOL);
	localparam int QIW       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int SW        = $clog2(QUEUE_DEPTH);
	localparam int CW        = $clog2(QUEUE_DEPTH + 1);
	localparam int DW        = $clog2(DRAIN_MAX + 1);
	localparam int HALF      = DRAIN_MAX / 2;
	localparam int ALARM_SET = (3 * QUEUE_DEPTH) / 4;
	localparam int ALARM_CLR = QUEUE_DEPTH / 2;

	localparam logic [3:0] ST_INIT    = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_PUT_POP = 4'd2;
	localparam logic [3:0] ST_PUT_ST  = 4'd3;
	localparam logic [3:0] ST_PUT_CHK = 4'd4;
	localparam logic [3:0] ST_REC_CHK = 4'd5;
	localparam logic [3:0] ST_DR_SCAN = 4'd6;
	localparam logic [3:0] ST_DR_OUT  = 4'd7;
	localparam logic [3:0] ST_EMIT    = 4'd8;

	logic [3:0]     state_q;
	logic [QIW-1:0] cur_q_q;
	logic [SW-1:0]  idle_head_q  [NUM_QUEUES];
	logic [CW-1:0]  idle_cnt_q   [NUM_QUEUES];
	logic [SW-1:0]  ready_head_q [NUM_QUEUES];
	logic [CW-1:0]  ready_cnt_q  [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] alarm_q;
	logic [6:0]     put_cnt_q;
	logic           first_q;
	logic           drain_q;
	logic [PW-1:0]  rec_idx_q;
	logic [DW-1:0]  drain_n_q;
	logic [PW-1:0]  sweep_q;
	bipm_res_t      pend_q;
	bipm_res_t      out_q;
	logic           out_valid_q;

	logic [SW-1:0]  ih, rh;
	logic [CW-1:0]  ic, rc;
	logic [PW-1:0]  base;
	logic [SW:0]    itail_sum, rtail_sum;
	logic [SW-1:0]  itail, rtail;
	logic [SW-1:0]  ih_inc, rh_inc;
	logic           wake;
	logic           emit_ok;

	logic           idle_we, idle_re;
	logic [PW-1:0]  idle_wa, idle_wd, idle_ra, idle_rd;
	logic           used_we, used_re, used_wd, used_rd;
	logic [PW-1:0]  used_wa, used_ra;
	logic           rdy_we, rdy_re;
	logic [PW-1:0]  rdy_wa, rdy_ra, rdy_rd;

	logic           claim, push_back, push_ready, rec_push;
	logic [CW-1:0]  rc_after;
	logic           more_hi, dr_last;

	// hysteresis on the ready fill level
	function automatic logic alarm_next(logic a, logic [CW-1:0] c);
		logic r;
		r = a;
		if (a) begin
			if (c < CW'(ALARM_CLR)) r = 1'b0;
		end else begin
			if (c > CW'(ALARM_SET)) r = 1'b1;
		end
		return r;
	endfunction

	// pointers of the current queue
	assign ih        = idle_head_q[cur_q_q];
	assign ic        = idle_cnt_q[cur_q_q];
	assign rh        = ready_head_q[cur_q_q];
	assign rc        = ready_cnt_q[cur_q_q];
	assign base      = PW'(32'(cur_q_q) * QUEUE_DEPTH);
	assign itail_sum = (SW+1)'(ih) + (SW+1)'(ic);
	assign rtail_sum = (SW+1)'(rh) + (SW+1)'(rc);
	assign itail     = (itail_sum >= (SW+1)'(QUEUE_DEPTH)) ?
		SW'(itail_sum - (SW+1)'(QUEUE_DEPTH)) : SW'(itail_sum);
	assign rtail     = (rtail_sum >= (SW+1)'(QUEUE_DEPTH)) ?
		SW'(rtail_sum - (SW+1)'(QUEUE_DEPTH)) : SW'(rtail_sum);
	assign ih_inc    = (ih == SW'(QUEUE_DEPTH - 1)) ? '0 : ih + 1'b1;
	assign rh_inc    = (rh == SW'(QUEUE_DEPTH - 1)) ? '0 : rh + 1'b1;
	assign wake      = (put_cnt_q > 7'(HALF));
	assign emit_ok   = !out_valid_q || !out_stall;

	// decisions on the words read back
	assign claim      = !used_rd;
	assign push_back  = claim && (rc == CW'(QUEUE_DEPTH));
	assign push_ready = claim && (rc != CW'(QUEUE_DEPTH));
	assign rc_after   = rc + CW'(push_ready);
	assign rec_push   = used_rd && (ic != CW'(QUEUE_DEPTH));

	// anything left to drain after the current index
	always_comb begin
		more_hi = 1'b0;
		for (int k = 0; k < NUM_QUEUES; k++) begin
			if (k > int'(cur_q_q) && ready_cnt_q[k] != '0) more_hi = 1'b1;
		end
	end
	assign dr_last = !(more_hi || rc != '0) || (drain_n_q == DW'(DRAIN_MAX - 1));

	// memory port control
	always_comb begin
		idle_we = (state_q == ST_INIT) || (state_q == ST_PUT_CHK && push_back) ||
			(state_q == ST_REC_CHK && rec_push);
		idle_wa = (state_q == ST_INIT) ? sweep_q : base + PW'(itail);
		idle_wd = (state_q == ST_INIT) ? sweep_q :
			((state_q == ST_PUT_CHK) ? idle_rd : rec_idx_q);
		idle_re = (state_q == ST_PUT_POP) && (ic != '0);
		idle_ra = base + PW'(ih);

		used_we = (state_q == ST_INIT) || (state_q == ST_PUT_CHK && claim) ||
			(state_q == ST_REC_CHK && used_rd);
		used_wa = (state_q == ST_INIT) ? sweep_q :
			((state_q == ST_PUT_CHK) ? idle_rd : rec_idx_q);
		used_wd = (state_q == ST_PUT_CHK);
		used_re = (state_q == ST_PUT_ST) ||
			(state_q == ST_IDLE && cq_valid && cq.op == OP_REC);
		used_ra = (state_q == ST_PUT_ST) ? idle_rd : PW'(cq.idx);

		rdy_we = (state_q == ST_PUT_CHK) && push_ready;
		rdy_wa = base + PW'(rtail);
		rdy_re = (state_q == ST_DR_SCAN) && (rc != '0);
		rdy_ra = base + PW'(rh);
	end

	bipm_ram #(.WIDTH(PW), .DEPTH(POOL)) u_idle_ram (
		.clk(clk), .we(idle_we), .waddr(idle_wa), .wdata(idle_wd),
		.re(idle_re), .raddr(idle_ra), .rdata(idle_rd)
	);

	bipm_ram #(.WIDTH(1), .DEPTH(POOL)) u_used_ram (
		.clk(clk), .we(used_we), .waddr(used_wa), .wdata(used_wd),
		.re(used_re), .raddr(used_ra), .rdata(used_rd)
	);

	bipm_ram #(.WIDTH(PW), .DEPTH(POOL)) u_ready_ram (
		.clk(clk), .we(rdy_we), .waddr(rdy_wa), .wdata(idle_rd),
		.re(rdy_re), .raddr(rdy_ra), .rdata(rdy_rd)
	);

	assign init_done = (state_q != ST_INIT);
	assign cq_take   = (state_q == ST_IDLE) && cq_valid;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// result payload register
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && emit_ok) begin
			out_q <= pend_q;
		end
	end

	// result valid: set on a new word, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && emit_ok) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cur_q_q     <= '0;
			alarm_q     <= '0;
			put_cnt_q   <= '0;
			first_q     <= 1'b0;
			drain_q     <= 1'b0;
			rec_idx_q   <= '0;
			drain_n_q   <= '0;
			sweep_q     <= '0;
			pend_q      <= '0;
			for (int k = 0; k < NUM_QUEUES; k++) begin
				idle_head_q[k]  <= '0;
				idle_cnt_q[k]   <= CW'(QUEUE_DEPTH);
				ready_head_q[k] <= '0;
				ready_cnt_q[k]  <= '0;
			end
		end else begin
			case (state_q)
				// fill the free lists and clear the in-use marks
				ST_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == PW'(POOL - 1)) state_q <= ST_IDLE;
				end
				// dispatch the next classified word
				ST_IDLE: begin
					if (cq_valid) begin
						drain_q <= (cq.op == OP_DRAIN);
						cur_q_q <= (cq.op == OP_DRAIN) ? '0 : QIW'(cq.q);
						case (cq.op)
							OP_PUT: begin
								if (put_cnt_q != COUNT_MAX) put_cnt_q <= put_cnt_q + 1'b1;
								pend_q  <= '0;
								first_q <= 1'b1;
								state_q <= ST_PUT_POP;
							end
							OP_REC: begin
								pend_q    <= '0;
								rec_idx_q <= PW'(cq.idx);
								state_q   <= ST_REC_CHK;
							end
							OP_DRAIN: begin
								drain_n_q <= '0;
								state_q   <= ST_DR_SCAN;
							end
							default: begin
								pend_q  <= {RC_RANGE, 10'd0, 1'b0, 1'b0, wake, 1'b1};
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				// take one index off the free list, or report no idle when it is empty
				ST_PUT_POP: begin
					if (ic == '0) begin
						pend_q.status <= RC_NO_IDLE;
						pend_q.wake   <= wake;
						pend_q.last   <= 1'b1;
						if (first_q) begin
							alarm_q[cur_q_q] <= alarm_next(alarm_q[cur_q_q], rc);
							pend_q.alarm     <= alarm_next(alarm_q[cur_q_q], rc);
						end else begin
							pend_q.alarm <= alarm_q[cur_q_q];
						end
						state_q <= ST_EMIT;
					end else begin
						idle_head_q[cur_q_q] <= ih_inc;
						idle_cnt_q[cur_q_q]  <= ic - 1'b1;
						state_q              <= ST_PUT_ST;
					end
				end
				// in-use mark of the popped index is being read
				ST_PUT_ST: begin
					state_q <= ST_PUT_CHK;
				end
				// skip an index in use, else claim it or report the ready list full
				ST_PUT_CHK: begin
					if (!claim) begin
						first_q <= 1'b0;
						state_q <= ST_PUT_POP;
					end else begin
						if (push_back) begin
							idle_cnt_q[cur_q_q] <= ic + 1'b1;
							pend_q.status       <= RC_READY_FULL;
						end else begin
							ready_cnt_q[cur_q_q] <= rc + 1'b1;
							pend_q.status        <= RC_OK;
							pend_q.index         <= 10'(idle_rd);
							pend_q.index_valid   <= 1'b1;
						end
						alarm_q[cur_q_q] <= alarm_next(alarm_q[cur_q_q], rc_after);
						pend_q.alarm     <= alarm_next(alarm_q[cur_q_q], rc_after);
						pend_q.wake      <= wake;
						pend_q.last      <= 1'b1;
						state_q          <= ST_EMIT;
					end
				end
				// return an in-use index to its owner
				ST_REC_CHK: begin
					if (!used_rd) begin
						pend_q.status <= RC_NOT_INUSE;
					end else if (rec_push) begin
						idle_cnt_q[cur_q_q] <= ic + 1'b1;
						pend_q.status       <= RC_OK;
					end else begin
						pend_q.status <= RC_IDLE_FULL;
					end
					pend_q.wake <= wake;
					pend_q.last <= 1'b1;
					state_q     <= ST_EMIT;
				end
				// find the next ready index
				ST_DR_SCAN: begin
					if (rc != '0) begin
						ready_head_q[cur_q_q] <= rh_inc;
						ready_cnt_q[cur_q_q]  <= rc - 1'b1;
						state_q               <= ST_DR_OUT;
					end else if (int'(cur_q_q) == NUM_QUEUES - 1) begin
						pend_q  <= {RC_OK, 10'd0, 1'b0, 1'b0, wake, 1'b1};
						state_q <= ST_EMIT;
					end else begin
						cur_q_q <= cur_q_q + 1'b1;
					end
				end
				// drained index is on the read port
				ST_DR_OUT: begin
					pend_q.status      <= RC_OK;
					pend_q.index       <= 10'(rdy_rd);
					pend_q.index_valid <= 1'b1;
					pend_q.alarm       <= 1'b0;
					pend_q.wake        <= wake;
					pend_q.last        <= dr_last;
					drain_n_q          <= drain_n_q + 1'b1;
					state_q            <= ST_EMIT;
				end
				// hand the result to the output register
				ST_EMIT: begin
					if (emit_ok) begin
						if (pend_q.last) begin
							if (drain_q) put_cnt_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DR_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hdl/buffer_index_pool_manager.sv
// top level of the buffer index pool manager
//
//  channel  direction  handshake            payload
//  in       to block   in_valid / in_stall  cmd, queue_sel, index_in, list_last
//  out      from block out_valid / out_stall status, index_out, index_valid,
//                                           alarm, wake, last
//
// a put pops the free list until it finds an index that is not in use, or
// until the free list runs out; a recycle checks the in-use mark of its index;
// a drain takes ready indices queue by queue, one result word per index taken.
// after reset a sweep of NUM_QUEUES*QUEUE_DEPTH indices fills the free lists;
// in_stall stays high during it. up to two words queue ahead of the
// sequencer, and a stalled output holds the sequencer in place.
`default_nettype none
module buffer_index_pool_manager #(
	parameter int NUM_QUEUES  = 4,
	parameter int QUEUE_DEPTH = 256,
	parameter int DRAIN_MAX   = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] cmd,
	input  wire logic [1:0] queue_sel,
	input  wire logic [9:0] index_in,
	input  wire logic       list_last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      status,
	output logic [9:0]      index_out,
	output logic            index_valid,
	output logic            alarm,
	output logic            wake,
	output logic            last
);
	import bipm_pkg::*;

	logic      init_done;
	logic      cq_valid;
	logic      cq_take;
	bipm_cmd_t cq;
	bipm_res_t res;

	bipm_front #(.NUM_QUEUES(NUM_QUEUES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .en(init_done),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
		.queue_sel(queue_sel), .index_in(index_in), .list_last(list_last),
		.cq_valid(cq_valid), .cq(cq), .cq_take(cq_take)
	);

	bipm_exec #(
		.NUM_QUEUES(NUM_QUEUES), .QUEUE_DEPTH(QUEUE_DEPTH), .DRAIN_MAX(DRAIN_MAX)
	) u_exec (
		.clk(clk), .arst_n(arst_n), .init_done(init_done),
		.cq_valid(cq_valid), .cq(cq), .cq_take(cq_take),
		.out_valid(out_valid), .out_stall(out_stall), .out_res(res)
	);

	// unpack the result word
	assign status      = res.status;
	assign index_out   = res.index;
	assign index_valid = res.index_valid;
	assign alarm       = res.alarm;
	assign wake        = res.wake;
	assign last        = res.last;
endmodule
`default_nettype wire

// File: hdl/bipm_checker.sv
// port-level checks for the buffer index pool manager and their bind
`default_nettype none
module bipm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [1:0] cmd,
	input wire logic [1:0] queue_sel,
	input wire logic [9:0] index_in,
	input wire logic       list_last,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [2:0] status,
	input wire logic [9:0] index_out,
	input wire logic       index_valid,
	input wire logic       alarm,
	input wire logic       wake,
	input wire logic       last
);
	import bipm_pkg::*;

	// a stalled command word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(cmd) && $stable(queue_sel) &&
		$stable(index_in) && $stable(list_last))
		else $error("command word changed under stall");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(index_out) && $stable(index_valid) && $stable(alarm) &&
		$stable(wake) && $stable(last))
		else $error("result word changed under stall");

	// an error status never carries an index
	a_err_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != RC_OK |-> !index_valid && index_out == 10'd0)
		else $error("index reported with error status");

	// a word without an index has a zero index field
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !index_valid |-> index_out == 10'd0)
		else $error("stray index value");

	// alarm only comes with ok, no idle or ready full status of a put
	a_alarm_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alarm |-> status == RC_OK || status == RC_NO_IDLE ||
		status == RC_READY_FULL)
		else $error("alarm on a word that is not a put result");
endmodule

bind buffer_index_pool_manager bipm_checker u_bipm_checker (.*);
`default_nettype wire
